[rtl/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the line splitter: result fields, codes and
// register map.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

    // Default width of the per-line byte counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Result queue between the framing logic and the output port
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_MAX_LINE_BYTES = 2'd0;
    localparam logic [1:0] REG_TRUNCATE_MODE  = 2'd1;
    localparam logic [1:0] REG_NUL_ERROR_EN   = 2'd2;

    localparam logic [15:0] MAX_LINE_BYTES_RST = 16'd4096;
    localparam logic        TRUNCATE_MODE_RST  = 1'b0;
    localparam logic        NUL_ERROR_EN_RST   = 1'b1;

    // Input commands
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Special bytes
    localparam logic [7:0] BYTE_NL  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_LINE_END = 2'd1,
        KIND_ERROR    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_FINISHED = 2'd0,
        ERR_NUL      = 2'd1,
        ERR_TOO_LONG = 2'd2
    } t_err;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       truncated;
        t_err       error_code;
        logic       last;
    } t_result;

    // Results produced by one request: count (0..2) and the two slots
    typedef struct packed {
        logic [1:0] n;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic [15:0] max_line_bytes;
        logic        truncate_mode;
        logic        nul_error_en;
    } t_cfg;

    function automatic t_result mk_result(t_kind kind, logic [7:0] b, logic trunc,
                                          t_err code, logic last);
        t_result r;
        r.kind       = kind;
        r.out_byte   = b;
        r.truncated  = trunc;
        r.error_code = code;
        r.last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/lsp_frame.sv]
// ----------------------------------------------------------------------------
// lsp_frame
// Line framing state and the single-pass decision for one request: which
// results it produces and how the line state moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_frame
    import lsp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_command,
    input  wire logic [7:0] i_data_byte,
    input  wire t_cfg       i_cfg,
    output t_push           o_push
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_cr, n_cr;
    logic                   r_trunc, n_trunc;
    logic                   r_fin, n_fin;
    logic                   room;
    t_push                  push;

    // Room left in the line; an all-ones count is a full line
    assign room = (CMP_W'(r_count) < CMP_W'(i_cfg.max_line_bytes))
               && (r_count != {COUNT_WIDTH{1'b1}});

    always_comb begin
        n_count = r_count;
        n_cr    = r_cr;
        n_trunc = r_trunc;
        n_fin   = r_fin;
        push.n    = 2'd0;
        push.res0 = mk_result(KIND_DATA, 8'd0, 1'b0, ERR_FINISHED, 1'b0);
        push.res1 = mk_result(KIND_DATA, 8'd0, 1'b0, ERR_FINISHED, 1'b0);

        if (i_command == CMD_FINISH) begin
            if (!r_fin) begin
                n_fin = 1'b1;
                // Flush a partial line, dropping a held carriage return
                if ((r_count != '0) || r_trunc) begin
                    push.n    = 2'd1;
                    push.res0 = mk_result(KIND_LINE_END, 8'd0, r_trunc, ERR_FINISHED, 1'b1);
                    n_count   = '0;
                    n_cr      = 1'b0;
                    n_trunc   = 1'b0;
                end
            end
        end else if (r_fin) begin
            push.n    = 2'd1;
            push.res0 = mk_result(KIND_ERROR, 8'd0, 1'b0, ERR_FINISHED, 1'b1);
        end else if ((i_data_byte == BYTE_NUL) && i_cfg.nul_error_en) begin
            push.n    = 2'd1;
            push.res0 = mk_result(KIND_ERROR, 8'd0, 1'b0, ERR_NUL, 1'b1);
        end else if (i_data_byte == BYTE_NL) begin
            push.n    = 2'd1;
            push.res0 = mk_result(KIND_LINE_END, 8'd0, r_trunc, ERR_FINISHED, 1'b1);
            n_count   = '0;
            n_cr      = 1'b0;
            n_trunc   = 1'b0;
        end else if (room) begin
            n_count = r_count + COUNT_WIDTH'(1);
            n_cr    = (i_data_byte == BYTE_CR);
            if (r_cr) begin
                // Release the held carriage return ahead of the new byte
                push.res0 = mk_result(KIND_DATA, BYTE_CR, 1'b0, ERR_FINISHED,
                                      i_data_byte == BYTE_CR);
                push.res1 = mk_result(KIND_DATA, i_data_byte, 1'b0, ERR_FINISHED, 1'b1);
                push.n    = (i_data_byte == BYTE_CR) ? 2'd1 : 2'd2;
            end else if (i_data_byte != BYTE_CR) begin
                push.n    = 2'd1;
                push.res0 = mk_result(KIND_DATA, i_data_byte, 1'b0, ERR_FINISHED, 1'b1);
            end
        end else if (!i_cfg.truncate_mode) begin
            push.n    = 2'd1;
            push.res0 = mk_result(KIND_ERROR, 8'd0, 1'b0, ERR_TOO_LONG, 1'b1);
        end else begin
            n_trunc = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cr    <= 1'b0;
            r_trunc <= 1'b0;
            r_fin   <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_cr    <= n_cr;
            r_trunc <= n_trunc;
            r_fin   <= n_fin;
        end
    end

    assign o_push = push;

    a_cr_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cr |-> (r_count != '0))
        else $error("held carriage return with an empty line");

    a_fin_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_fin)
        else $error("finished flag cleared without reset");

    a_pair_leads_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n == 2'd2) |-> ((push.res0.kind == KIND_DATA)
                              && (push.res0.out_byte == BYTE_CR) && !push.res0.last))
        else $error("two results without a released carriage return first");

endmodule

`default_nettype wire

[rtl/line_splitter.sv]
// ----------------------------------------------------------------------------
// line_splitter
// Splits a byte stream into newline-terminated lines.
//
// Input channel (i_valid / o_stall): one request per cycle, either a data
// byte or a finish command. Output channel (o_valid / i_stall): result items
// (line data byte, line end marker with truncation flag, or error); o_last
// marks the last result of a request. A request gives zero, one or two results.
// Each result is written into the result queue when its request is accepted.
// Throughput: one request per cycle while the receiver keeps up; a request
// that gives two results (held carriage return released) fills the 4-entry
// result queue one slot faster, and o_stall rises while fewer than two slots
// are free. When the receiver stalls, the queue holds its results and the head
// stays on the output unchanged. Reset empties the queue, clears the line state
// and loads the register defaults (4096 bytes per line, error on overlong lines,
// NUL rejected). The user must write registers over the APB port only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module line_splitter
    import lsp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_command,
    input  wire logic [7:0]        i_data_byte,
    // output channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_truncated,
    output logic [1:0]             o_error_code,
    output logic                   o_last,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_cfg              r_cfg;
    t_push             push;
    logic              accept;
    logic              pop;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    t_result           r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [1:0]        push_n;
    t_result           head;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_line_bytes <= MAX_LINE_BYTES_RST;
            r_cfg.truncate_mode  <= TRUNCATE_MODE_RST;
            r_cfg.nul_error_en   <= NUL_ERROR_EN_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MAX_LINE_BYTES: r_cfg.max_line_bytes <= pwdata[15:0];
                REG_TRUNCATE_MODE:  r_cfg.truncate_mode  <= pwdata[0];
                REG_NUL_ERROR_EN:   r_cfg.nul_error_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_LINE_BYTES: prdata = APB_DW'(r_cfg.max_line_bytes);
            REG_TRUNCATE_MODE:  prdata = APB_DW'(r_cfg.truncate_mode);
            REG_NUL_ERROR_EN:   prdata = APB_DW'(r_cfg.nul_error_en);
            default:            prdata = '0;
        endcase
    end

    // ---------------- framing ----------------
    assign o_stall = (r_count > QCNT_W'(QUEUE_DEPTH - 2));
    assign accept  = i_valid && !o_stall;

    lsp_frame #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_push      (push)
    );

    // ---------------- result queue ----------------
    assign push_n  = accept ? push.n : 2'd0;
    assign pop     = o_valid && !i_stall;
    assign n_count = r_count + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= push.res0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= push.res1;
        end
    end

    assign head         = r_queue[r_rd_ptr];
    assign o_valid      = (r_count != '0);
    assign o_kind       = head.kind;
    assign o_out_byte   = head.out_byte;
    assign o_truncated  = head.truncated;
    assign o_error_code = head.error_code;
    assign o_last       = head.last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_ERROR)) |-> o_last)
        else $error("error result not last of its request");

    a_line_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_LINE_END)) |-> (o_last && (o_out_byte == 8'd0)))
        else $error("line end result malformed");

endmodule

`default_nettype wire

[dv/line_splitter_checker.sv]
// ----------------------------------------------------------------------------
// line_splitter_checker
// Watches the request, result and APB channels of the line splitter. It keeps
// its own copy of the line state and registers, works out the results that
// each accepted request should give, and compares every accepted result
// field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module line_splitter_checker
    import lsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire logic              req_command,
    input  wire logic [7:0]        req_byte,
    // result channel
    input  wire logic              res_valid,
    input  wire logic              res_stall,
    input  wire logic [1:0]        res_kind,
    input  wire logic [7:0]        res_byte,
    input  wire logic              res_truncated,
    input  wire logic [1:0]        res_error_code,
    input  wire logic              res_last,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    // status for the testbench top
    output int                     fail_count,
    output int                     pending,
    output int                     request_count,
    output int                     result_count,
    output int                     line_count,
    output int                     error_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W = COUNT_WIDTH_DEF;

    // register copy
    logic [15:0]        cfg_max_len;
    logic               cfg_truncate;
    logic               cfg_nul_error_en;

    // line state
    logic [COUNT_W-1:0] line_len;
    logic               cr_held;
    logic               line_cut;
    logic               eos_seen;

    t_result            expected_results [$];

    task automatic report_mismatch(input string field, input int got, input int want);
        if (fail_count < 30) begin
            $display("[%0t] mismatch on result %0d: %s is %0h, expected %0h",
                     $time, result_count, field, got, want);
        end
        fail_count++;
    endtask

    function automatic t_result make_item(t_kind kind, logic [7:0] b, logic trunc,
                                          t_err code);
        t_result r;
        r.kind       = kind;
        r.out_byte   = b;
        r.truncated  = trunc;
        r.error_code = code;
        r.last       = 1'b0;
        return r;
    endfunction

    // Close the current line; a held carriage return is dropped here.
    function automatic t_result end_line();
        t_result r;
        r        = make_item(KIND_LINE_END, 8'h00, line_cut, ERR_FINISHED);
        line_len = '0;
        cr_held  = 1'b0;
        line_cut = 1'b0;
        return r;
    endfunction

    task automatic frame_request(input logic cmd, input logic [7:0] b);
        t_result outs [2];
        int      n;
        n = 0;
        request_count++;
        if (cmd == CMD_FINISH) begin
            if (!eos_seen) begin
                eos_seen = 1'b1;
                if (line_len != '0 || line_cut) begin
                    outs[0] = end_line();
                    n = 1;
                end
            end
        end else if (eos_seen) begin
            outs[0] = make_item(KIND_ERROR, 8'h00, 1'b0, ERR_FINISHED);
            n = 1;
        end else if (b == BYTE_NUL && cfg_nul_error_en) begin
            outs[0] = make_item(KIND_ERROR, 8'h00, 1'b0, ERR_NUL);
            n = 1;
        end else if (b == BYTE_NL) begin
            outs[0] = end_line();
            n = 1;
        end else if (line_len < cfg_max_len && line_len != '1) begin
            line_len = line_len + COUNT_W'(1);
            // release the held carriage return ahead of the new byte
            if (cr_held) begin
                outs[n] = make_item(KIND_DATA, BYTE_CR, 1'b0, ERR_FINISHED);
                n++;
            end
            if (b == BYTE_CR) begin
                cr_held = 1'b1;
            end else begin
                cr_held = 1'b0;
                outs[n] = make_item(KIND_DATA, b, 1'b0, ERR_FINISHED);
                n++;
            end
        end else if (!cfg_truncate) begin
            outs[0] = make_item(KIND_ERROR, 8'h00, 1'b0, ERR_TOO_LONG);
            n = 1;
        end else begin
            line_cut = 1'b1;
        end

        if (n > 0) begin
            outs[n-1].last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            expected_results.insert(expected_results.size(), outs[k]);
        end
    endtask

    task automatic check_result();
        t_result want;
        result_count++;
        if (expected_results.size() == 0) begin
            report_mismatch("result with none expected, kind", res_kind, 0);
            return;
        end
        want = expected_results.pop_front();
        if (want.kind == KIND_LINE_END) line_count++;
        if (want.kind == KIND_ERROR) error_count++;
        if (res_kind !== want.kind)
            report_mismatch("kind", res_kind, want.kind);
        if (res_byte !== want.out_byte)
            report_mismatch("out_byte", res_byte, want.out_byte);
        if (res_truncated !== want.truncated)
            report_mismatch("truncated", res_truncated, want.truncated);
        if (res_error_code !== want.error_code)
            report_mismatch("error_code", res_error_code, want.error_code);
        if (res_last !== want.last)
            report_mismatch("last", res_last, want.last);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_max_len      = MAX_LINE_BYTES_RST;
            cfg_truncate     = TRUNCATE_MODE_RST;
            cfg_nul_error_en = NUL_ERROR_EN_RST;
            line_len         = '0;
            cr_held          = 1'b0;
            line_cut         = 1'b0;
            eos_seen         = 1'b0;
            expected_results.delete();
            fail_count       = 0;
            request_count    = 0;
            result_count     = 0;
            line_count       = 0;
            error_count      = 0;
        end else begin
            // compare before predicting: a result never answers a request
            // accepted at the same edge
            if (res_valid && !res_stall) check_result();
            if (req_valid && !req_stall) frame_request(req_command, req_byte);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MAX_LINE_BYTES: cfg_max_len      = pwdata[15:0];
                    REG_TRUNCATE_MODE:  cfg_truncate     = pwdata[0];
                    REG_NUL_ERROR_EN:   cfg_nul_error_en = pwdata[0];
                    default: ;
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Top of the line splitter testbench. Drives byte and finish requests, APB
// register writes and receiver stalls; the checker beside the block predicts
// and compares every result. Directed lines cover the held carriage return,
// NUL, overlong and finish cases; random lines run under several settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import lsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_command;
    logic [7:0]        i_data_byte;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_kind;
    logic [7:0]        o_out_byte;
    logic              o_truncated;
    logic [1:0]        o_error_code;
    logic              o_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int request_count;
    int result_count;
    int line_count;
    int error_count;

    int cycles;
    int hold_cycles;
    bit rx_idle_on;
    int settings;
    int finish_case;

    line_splitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_truncated  (o_truncated),
        .o_error_code (o_error_code),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    line_splitter_checker u_checker (
        .clk            (i_clk),
        .rst_n          (i_rst_n),
        .req_valid      (i_valid),
        .req_stall      (o_stall),
        .req_command    (i_command),
        .req_byte       (i_data_byte),
        .res_valid      (o_valid),
        .res_stall      (i_stall),
        .res_kind       (o_kind),
        .res_byte       (o_out_byte),
        .res_truncated  (o_truncated),
        .res_error_code (o_error_code),
        .res_last       (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .request_count  (request_count),
        .result_count   (result_count),
        .line_count     (line_count),
        .error_count    (error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
                i_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(input logic cmd, input logic [7:0] b, input int gap);
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_data_byte <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte(input bit after_cr);
        int r;
        r = $urandom_range(0, 99);
        if (after_cr && r < 50) return BYTE_NL;
        if (r < 8) return BYTE_NL;
        if (r < 18) return BYTE_CR;
        if (r < 21) return BYTE_NUL;
        if (r < 32) return 8'($urandom);
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    // Random lines: mostly text, with CR, CRLF, NUL and raw bytes mixed in.
    task automatic send_lines(input int count, input bit gaps);
        logic [7:0] b;
        bit         after_cr;
        int         gap;
        after_cr = 1'b0;
        for (int k = 0; k < count; k++) begin
            b        = pick_byte(after_cr);
            after_cr = (b == BYTE_CR);
            gap      = (gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
            send_req(CMD_DATA, b, gap);
        end
    endtask

    // Hold the input until every outstanding result has come, then let the
    // block settle on requests that gave no result.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] max_len, input logic trunc,
                              input logic nul);
        drain();
        write_reg(REG_MAX_LINE_BYTES, 32'(max_len));
        write_reg(REG_TRUNCATE_MODE, 32'(trunc));
        write_reg(REG_NUL_ERROR_EN, 32'(nul));
        settings++;
    endtask

    initial begin
        logic [7:0] opening [13] = '{8'h61, 8'hFF, BYTE_NUL, BYTE_CR, BYTE_CR, 8'h62,
                                     BYTE_CR, BYTE_NL, BYTE_NL, 8'h80, 8'h7F, BYTE_CR,
                                     BYTE_NL};
        logic [7:0] overlong [4] = '{8'h63, 8'h64, 8'h65, BYTE_NL};
        logic [7:0] held_cut [4] = '{8'h66, BYTE_CR, 8'h67, BYTE_NL};
        logic [7:0] too_long [4] = '{8'h68, 8'h69, 8'h6A, BYTE_NL};
        logic [7:0] after_eos [5] = '{8'h7A, BYTE_NL, BYTE_NUL, BYTE_CR, 8'hFF};

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = CMD_DATA;
        i_data_byte = 8'h00;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        hold_cycles = 0;
        rx_idle_on  = 1'b1;
        settings    = 1;
        finish_case = $urandom_range(0, 2);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: byte extremes, NUL, held and doubled carriage returns
        foreach (opening[k]) send_req(CMD_DATA, opening[k], 0);

        // two-byte lines, overlong bytes dropped, then rejected
        set_config(16'd2, 1'b1, 1'b1);
        foreach (overlong[k]) send_req(CMD_DATA, overlong[k], 0);
        foreach (held_cut[k]) send_req(CMD_DATA, held_cut[k], 0);
        drain();
        write_reg(REG_TRUNCATE_MODE, 32'(1'b0));
        settings++;
        foreach (too_long[k]) send_req(CMD_DATA, too_long[k], 0);

        set_config(16'd3, 1'b0, 1'b1);
        send_lines(100, 1'b1);
        // long receiver hold-off while the sender keeps pushing
        hold_cycles = 200;
        send_lines(40, 1'b0);
        send_lines(160, 1'b1);

        set_config(16'd0, 1'b1, 1'b0);
        send_lines(250, 1'b1);

        set_config(16'd5, 1'b1, 1'b1);
        send_lines(150, 1'b1);
        drain();
        send_lines(150, 1'b1);

        set_config(16'hFFFF, 1'b0, 1'b0);
        send_lines(300, 1'b1);

        set_config(16'd1, 1'b0, 1'b0);
        send_lines(300, 1'b1);

        // last part: no idling on either side
        set_config(16'd8, 1'b1, 1'b1);
        rx_idle_on = 1'b0;
        send_lines(400, 1'b0);

        // end of stream: empty line, held carriage return, or truncated line
        case (finish_case)
            0: send_req(CMD_DATA, BYTE_NL, 0);
            1: begin
                send_req(CMD_DATA, 8'h61, 0);
                send_req(CMD_DATA, BYTE_CR, 0);
            end
            default: begin
                send_req(CMD_DATA, BYTE_NL, 0);
                repeat (10) send_req(CMD_DATA, 8'h71, 0);
            end
        endcase
        send_req(CMD_FINISH, 8'h00, 0);
        send_req(CMD_FINISH, 8'hFF, 0);
        foreach (after_eos[k]) send_req(CMD_DATA, after_eos[k], 0);

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests under %0d register settings, finish case %0d.",
                 request_count, settings, finish_case);
        $display("Checked %0d results: %0d line ends, %0d errors, %0d mismatches.",
                 result_count, line_count, error_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
